### hw/rtl/tnc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types and constants of the two-note chime generator.
// ----------------------------------------------------------------------------
package tnc_pkg;

   localparam int SINE_TABLE_ENTRIES_DEFAULT = 1024;

   localparam int IDX_W   = 16;
   localparam int PCM_W   = 16;
   localparam int AMP_W   = 15;
   localparam int STEP_W  = 24;
   localparam int LOCAL_W = 11;
   localparam int ENV_W   = 16;
   localparam int SINE_W  = 15;
   localparam int FRAC_W  = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [IDX_W-1:0] NOTE_ONE_END   = 16'd1600;
   localparam logic [IDX_W-1:0] NOTE_TWO_START = 16'd2240;
   localparam logic [IDX_W-1:0] NOTE_TWO_END   = 16'd4160;

   localparam logic [LOCAL_W-1:0] ATTACK_LEN  = 11'd192;
   localparam logic [LOCAL_W-1:0] RELEASE_LEN = 11'd400;
   localparam logic [ENV_W-1:0]   ENV_ONE     = 16'd32768;

   // floor(v/3) = (v * ATT_RECIP) >> 19, exact for v < 2^19
   localparam logic [17:0] ATT_RECIP = 18'd174763;
   localparam int          ATT_SHIFT = 19;
   // floor(v/25) = (v * REL_RECIP) >> 30, exact for v < 2^30
   localparam logic [25:0] REL_RECIP = 26'd42949673;
   localparam int          REL_SHIFT = 30;

   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam logic [63:0] HALF_Q30     = 64'd536870912;
   localparam logic [63:0] SINE_MAX     = 64'd32767;
   localparam int          Q30_SHIFT    = 30;

   localparam logic [AMP_W-1:0]  AMPLITUDE_RESET   = 15'd4500;
   localparam logic [STEP_W-1:0] FIRST_STEP_RESET  = 24'd922747;
   localparam logic [STEP_W-1:0] SECOND_STEP_RESET = 24'd1231720;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMPLITUDE   = 2'd0,
      CSR_FIRST_STEP  = 2'd1,
      CSR_SECOND_STEP = 2'd2
   } csr_index_type;

endpackage
`default_nettype wire

### hw/rtl/tnc_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tnc_sine_rom
// Quarter-wave sine table, Q0.15 magnitudes, one registered read port.
// ----------------------------------------------------------------------------
module tnc_sine_rom #(
   parameter int SINE_TABLE_ENTRIES = tnc_pkg::SINE_TABLE_ENTRIES_DEFAULT,
   parameter int ADDR_W = $clog2(SINE_TABLE_ENTRIES / 4 + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [tnc_pkg::SINE_W-1:0] rd_data
);
   import tnc_pkg::*;

   localparam int QUARTER_LEN = SINE_TABLE_ENTRIES / 4;

   logic [SINE_W-1:0] rom_table [QUARTER_LEN+1];
   logic [SINE_W-1:0] rd_data_ff;

   // Taylor series to x^15 in unsigned Q30, each term truncated
   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      begin
         x    = (HALF_PI_Q30 * 64'(k)) / QUARTER_LEN;
         x2   = (x * x) >> Q30_SHIFT;
         sum  = x;
         term = ((x * x2) >> Q30_SHIFT) / 6;
         sum  = (term > sum) ? 64'd0 : sum - term;
         term = ((term * x2) >> Q30_SHIFT) / 20;
         sum  = sum + term;
         term = ((term * x2) >> Q30_SHIFT) / 42;
         sum  = (term > sum) ? 64'd0 : sum - term;
         term = ((term * x2) >> Q30_SHIFT) / 72;
         sum  = sum + term;
         term = ((term * x2) >> Q30_SHIFT) / 110;
         sum  = (term > sum) ? 64'd0 : sum - term;
         term = ((term * x2) >> Q30_SHIFT) / 156;
         sum  = sum + term;
         term = ((term * x2) >> Q30_SHIFT) / 210;
         sum  = (term > sum) ? 64'd0 : sum - term;
         v    = (sum * SINE_MAX + HALF_Q30) >> Q30_SHIFT;
         if (v > SINE_MAX) begin
            v = SINE_MAX;
         end
         sine_entry = v[SINE_W-1:0];
      end
   endfunction

   for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_rom
      assign rom_table[g] = sine_entry(g);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_table[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/two_note_chime_synth.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_note_chime_synth
// Maps a 16 kHz sample index to one signed chime sample: two sine notes
// under a linear attack/release envelope, scaled by a programmable level.
//
//   channel  direction  handshake                 payload
//   req_     in         req_valid / req_stall     req_sample_index [15:0]
//   rsp_     out        rsp_valid / rsp_stall     rsp_pcm_sample   [15:0] signed
//   csr_     in         csr_valid / csr_ready     csr_index [1:0], csr_data [23:0]
//
// Five register stages: decode, phase and envelope products, envelope minimum
// and table address, table read with level times envelope, final scale.
// A transaction passes the decode, product, address, table and output registers
// in order before it is offered on rsp_; one transaction per cycle sustained while rsp_stall is low.
// reset is synchronous: it empties the pipeline and loads the register
// defaults. Stage enables chain combinationally: rsp_stall reaches req_stall in
// the same cycle once every stage is full; an empty stage absorbs a stall.
// ----------------------------------------------------------------------------
module two_note_chime_synth #(
   parameter int SINE_TABLE_ENTRIES = tnc_pkg::SINE_TABLE_ENTRIES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [tnc_pkg::IDX_W-1:0]       req_sample_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [tnc_pkg::PCM_W-1:0]     rsp_pcm_sample,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tnc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tnc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tnc_pkg::*;

   localparam int QUARTER_LEN = SINE_TABLE_ENTRIES / 4;
   localparam int ADDR_W      = $clog2(QUARTER_LEN + 1);
   localparam int KP_W        = FRAC_W + ADDR_W;

   // configuration
   logic [AMP_W-1:0]  amplitude_ff;
   logic [STEP_W-1:0] first_step_ff;
   logic [STEP_W-1:0] second_step_ff;

   // stage ready chain
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // stage 1: decode
   logic               s1_valid_ff;
   logic               s1_active_ff,  s1_active_in;
   logic [LOCAL_W-1:0] s1_local_ff,   s1_local_in;
   logic [LOCAL_W-1:0] s1_remain_ff,  s1_remain_in;
   logic [STEP_W-1:0]  s1_step_ff,    s1_step_in;

   // stage 2: phase and envelope candidates
   logic               s2_valid_ff;
   logic               s2_active_ff;
   logic [STEP_W-1:0]  s2_phase_ff,   s2_phase_in;
   logic [ENV_W-1:0]   s2_att_ff,     s2_att_in;
   logic [ENV_W-1:0]   s2_rel_ff,     s2_rel_in;
   logic [LOCAL_W+STEP_W-1:0] phase_prod;
   logic [34:0]        att_prod;
   logic [45:0]        rel_prod;

   // stage 3: envelope minimum and table address
   logic               s3_valid_ff;
   logic               s3_active_ff;
   logic               s3_neg_ff;
   logic [ENV_W-1:0]   s3_env_ff,     s3_env_in;
   logic [ADDR_W-1:0]  s3_addr_ff,    s3_addr_in;
   logic [KP_W-1:0]    k_prod;
   logic [ADDR_W-1:0]  k_idx;

   // stage 4: table read and level times envelope
   logic                    s4_valid_ff;
   logic                    s4_active_ff;
   logic                    s4_neg_ff;
   logic [AMP_W+ENV_W-1:0]  s4_ampenv_ff;
   logic [SINE_W-1:0]       sine_mag;

   // stage 5: output
   logic                         rsp_valid_ff;
   logic signed [PCM_W-1:0]      rsp_pcm_ff,  rsp_pcm_in;
   logic [AMP_W+ENV_W+SINE_W-1:0] out_prod;
   logic [PCM_W-1:0]             out_mag;

   assign rdy5 = !rsp_valid_ff || !rsp_stall;
   assign rdy4 = !s4_valid_ff || rdy5;
   assign rdy3 = !s3_valid_ff || rdy4;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;

   assign req_stall      = !rdy1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_sample = rsp_pcm_ff;
   assign csr_ready      = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff   <= AMPLITUDE_RESET;
         first_step_ff  <= FIRST_STEP_RESET;
         second_step_ff <= SECOND_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AMPLITUDE:   amplitude_ff   <= csr_data[AMP_W-1:0];
            CSR_FIRST_STEP:  first_step_ff  <= csr_data[STEP_W-1:0];
            CSR_SECOND_STEP: second_step_ff <= csr_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1
   always_comb begin
      s1_active_in = 1'b1;
      s1_local_in  = req_sample_index[LOCAL_W-1:0];
      s1_remain_in = LOCAL_W'(NOTE_ONE_END - req_sample_index);
      s1_step_in   = first_step_ff;
      if (req_sample_index < NOTE_ONE_END) begin
         s1_active_in = 1'b1;
      end else if (req_sample_index >= NOTE_TWO_START &&
                   req_sample_index < NOTE_TWO_END) begin
         s1_local_in  = LOCAL_W'(req_sample_index - NOTE_TWO_START);
         s1_remain_in = LOCAL_W'(NOTE_TWO_END - req_sample_index);
         s1_step_in   = second_step_ff;
      end else begin
         s1_active_in = 1'b0;
      end
   end

   // stage 2
   assign phase_prod = (LOCAL_W+STEP_W)'(s1_local_ff) * (LOCAL_W+STEP_W)'(s1_step_ff);
   assign s2_phase_in = phase_prod[STEP_W-1:0];
   assign att_prod   = 35'({s1_local_ff[7:0], 9'd0}) * 35'(ATT_RECIP);
   assign rel_prod   = 46'({s1_remain_ff[8:0], 11'd0}) * 46'(REL_RECIP);
   assign s2_att_in  = (s1_local_ff < ATTACK_LEN) ? att_prod[ATT_SHIFT +: ENV_W] : ENV_ONE;
   assign s2_rel_in  = (s1_remain_ff < RELEASE_LEN) ? rel_prod[REL_SHIFT +: ENV_W] : ENV_ONE;

   // stage 3
   assign s3_env_in  = (s2_att_ff < s2_rel_ff) ? s2_att_ff : s2_rel_ff;
   assign k_prod     = KP_W'(s2_phase_ff[FRAC_W-1:0]) * KP_W'(QUARTER_LEN);
   assign k_idx      = k_prod[FRAC_W +: ADDR_W];
   assign s3_addr_in = s2_phase_ff[FRAC_W] ? ADDR_W'(QUARTER_LEN) - k_idx : k_idx;

   // stage 5
   assign out_prod = (AMP_W+ENV_W+SINE_W)'(s4_ampenv_ff) * (AMP_W+ENV_W+SINE_W)'(sine_mag);
   assign out_mag  = out_prod[Q30_SHIFT +: PCM_W];
   always_comb begin
      if (!s4_active_ff) begin
         rsp_pcm_in = '0;
      end else if (s4_neg_ff) begin
         rsp_pcm_in = -$signed(out_mag);
      end else begin
         rsp_pcm_in = $signed(out_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff  <= req_valid;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) s4_valid_ff  <= s3_valid_ff;
         if (rdy5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_active_ff <= s1_active_in;
         s1_local_ff  <= s1_local_in;
         s1_remain_ff <= s1_remain_in;
         s1_step_ff   <= s1_step_in;
      end
      if (rdy2) begin
         s2_active_ff <= s1_active_ff;
         s2_phase_ff  <= s2_phase_in;
         s2_att_ff    <= s2_att_in;
         s2_rel_ff    <= s2_rel_in;
      end
      if (rdy3) begin
         s3_active_ff <= s2_active_ff;
         s3_neg_ff    <= s2_phase_ff[STEP_W-1];
         s3_env_ff    <= s3_env_in;
         s3_addr_ff   <= s3_addr_in;
      end
      if (rdy4) begin
         s4_active_ff <= s3_active_ff;
         s4_neg_ff    <= s3_neg_ff;
         s4_ampenv_ff <= (AMP_W+ENV_W)'(amplitude_ff) * (AMP_W+ENV_W)'(s3_env_ff);
      end
      if (rdy5) begin
         rsp_pcm_ff   <= rsp_pcm_in;
      end
   end

   tnc_sine_rom #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
      .ADDR_W             (ADDR_W)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (rdy4),
      .rd_addr (s3_addr_ff),
      .rd_data (sine_mag)
   );

`ifndef NO_ASSERTIONS
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_env_ff <= ENV_ONE)
      else $error("envelope above unity");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_addr_ff <= ADDR_W'(QUARTER_LEN))
      else $error("sine table address out of range");

   a_silent_gap: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !s4_active_ff && rdy5 |=> rsp_pcm_sample == '0)
      else $error("nonzero sample outside notes");

   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pcm_sample != {1'b1, {(PCM_W-1){1'b0}}})
      else $error("sample magnitude overflow");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rdy2 |=> s1_valid_ff && $stable(s1_local_ff))
      else $error("stalled decode stage lost its transaction");
`endif

endmodule
`default_nettype wire
